### rtl/ash_pkg.sv
// Package for the annular sector hit test.
// Holds widths, configuration register indexes and the CORDIC arctangent table.
// No dependencies.
package ash_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int ANGLE_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;

  localparam int ATAN_LEN    = 24;
  localparam int SCALE_SHIFT = 29;
  localparam int XY_W        = 64;
  localparam int Z_W         = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (COORD_WIDTH > ANGLE_WIDTH + 2) ? COORD_WIDTH : ANGLE_WIDTH + 2;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_ANGLE  = 3'd5;

  localparam logic [Z_W-1:0] Z_HALF    = 32'h8000_0000;
  localparam logic [Z_W-1:0] ANG_ROUND = 32'd1 << (31 - ANGLE_WIDTH);

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [Z_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

### rtl/annular_sector_hit_test.sv
// Throughput: one item per cycle while the skid register is empty; each CORDIC stage holds one iteration.
// A one-entry skid register behind the last stage absorbs an output stall.
// Reset: asynchronous, active low; clears valid bits, skid flag and configuration registers.
// Annular sector hit test: radial check on exact squares, angle by pipelined CORDIC atan2.
// Depends on ash_pkg.
module annular_sector_hit_test (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [ash_pkg::COORD_WIDTH-1:0] point_x_i,
  input  logic signed [ash_pkg::COORD_WIDTH-1:0] point_y_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  inside_res_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ash_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [ash_pkg::CFG_DATA_W-1:0]         cfg_data_i
);
  import ash_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int AW = ANGLE_WIDTH;
  localparam int CS = CORDIC_STAGES;
  localparam int P  = CS + 3;

  // configuration
  logic signed [CW-1:0] center_x_q, center_y_q;
  logic [CW-2:0]        outer_q, inner_q;
  logic [AW-1:0]        start_q;
  logic signed [AW+1:0] sweep_q;
  logic [2*CW-3:0]      o2_q, i2_q, o2_d, i2_d;
  logic                 sweep_neg_q, sweep_neg_d, sweep_full_q, sweep_full_d;
  logic [AW+1:0]        sweep_mag_q, sweep_mag_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      outer_q    <= '0;
      inner_q    <= '0;
      start_q    <= '0;
      sweep_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CENTER_X:     center_x_q <= cfg_data_i[CW-1:0];
        REG_CENTER_Y:     center_y_q <= cfg_data_i[CW-1:0];
        REG_OUTER_RADIUS: outer_q    <= cfg_data_i[CW-2:0];
        REG_INNER_RADIUS: inner_q    <= cfg_data_i[CW-2:0];
        REG_START_ANGLE:  start_q    <= cfg_data_i[AW-1:0];
        REG_SWEEP_ANGLE:  sweep_q    <= cfg_data_i[AW+1:0];
        default: ;
      endcase
    end
  end

  assign o2_d         = outer_q * outer_q;
  assign i2_d         = inner_q * inner_q;
  assign sweep_neg_d  = sweep_q[AW+1];
  assign sweep_mag_d  = sweep_neg_d ? (AW+2)'(-sweep_q) : sweep_q;
  assign sweep_full_d = |sweep_mag_d[AW+1:AW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o2_q         <= '0;
      i2_q         <= '0;
      sweep_neg_q  <= 1'b0;
      sweep_mag_q  <= '0;
      sweep_full_q <= 1'b0;
    end else begin
      o2_q         <= o2_d;
      i2_q         <= i2_d;
      sweep_neg_q  <= sweep_neg_d;
      sweep_mag_q  <= sweep_mag_d;
      sweep_full_q <= sweep_full_d;
    end
  end

  // pipeline control
  logic         en;
  logic [P-1:0] v_q, v_d;
  logic         skid_v_q, skid_v_d, skid_q, skid_d;

  assign en         = !skid_v_q;
  assign in_ready_o = en;
  assign v_d        = {v_q[P-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= v_d;
    end
  end

  // stage 0: offsets from center
  logic signed [CW:0] dx_q, dy_q, dx_d, dy_d;
  assign dx_d = (CW+1)'(point_x_i) - (CW+1)'(center_x_q);
  assign dy_d = (CW+1)'(point_y_i) - (CW+1)'(center_y_q);

  // stage 1: squares, far flag, CORDIC pre-rotation
  logic signed [CW-1:0]   dxs, dys;
  logic signed [2*CW-1:0] sqx_full, sqy_full;
  logic [2*CW-3:0]        sqx_q, sqy_q, sqx_d, sqy_d;
  logic                   far_q, far_d, far2_q;
  logic                   far_x, far_y;
  assign dxs      = dx_q[CW-1:0];
  assign dys      = dy_q[CW-1:0];
  assign sqx_full = dxs * dxs;
  assign sqy_full = dys * dys;
  assign sqx_d    = sqx_full[2*CW-3:0];
  assign sqy_d    = sqy_full[2*CW-3:0];
  assign far_x    = (dx_q[CW] != dx_q[CW-1]) ||
                    (dx_q[CW] && (dx_q[CW-1:0] == {1'b1, {(CW-1){1'b0}}}));
  assign far_y    = (dy_q[CW] != dy_q[CW-1]) ||
                    (dy_q[CW] && (dy_q[CW-1:0] == {1'b1, {(CW-1){1'b0}}}));
  assign far_d    = far_x || far_y;

  logic signed [XY_W-1:0] x_q [CS+1];
  logic signed [XY_W-1:0] y_q [CS+1];
  logic [Z_W-1:0]         z_q [CS+1];
  logic signed [XY_W-1:0] x_d [CS+1];
  logic signed [XY_W-1:0] y_d [CS+1];
  logic [Z_W-1:0]         z_d [CS+1];
  logic signed [XY_W-1:0] xe, ye;

  assign xe     = XY_W'(dx_q) <<< SCALE_SHIFT;
  assign ye     = XY_W'(dy_q) <<< SCALE_SHIFT;
  assign x_d[0] = xe[XY_W-1] ? -xe : xe;
  assign y_d[0] = xe[XY_W-1] ? -ye : ye;
  assign z_d[0] = xe[XY_W-1] ? Z_HALF : '0;

  for (genvar k = 0; k < CS; k++) begin : g_cordic
    logic signed [XY_W-1:0] xs, ys;
    assign xs       = x_q[k] >>> k;
    assign ys       = y_q[k] >>> k;
    assign x_d[k+1] = y_q[k][XY_W-1] ? x_q[k] - ys : x_q[k] + ys;
    assign y_d[k+1] = y_q[k][XY_W-1] ? y_q[k] + xs : y_q[k] - xs;
    assign z_d[k+1] = y_q[k][XY_W-1] ? z_q[k] - ATAN_TAB[k] : z_q[k] + ATAN_TAB[k];
  end

  // stage 2: squared distance; stage 3: radial bounds
  logic [2*CW-2:0] d2_q, d2_d;
  logic [CS+1:3]   rad_q, rad_d;
  assign d2_d = (2*CW-1)'(sqx_q) + (2*CW-1)'(sqy_q);
  assign rad_d = {rad_q[CS:3],
                  !far2_q && (d2_q < (2*CW-1)'(o2_q)) && (d2_q > (2*CW-1)'(i2_q))};

  // last stage: round angle, sweep test
  logic [Z_W-1:0] zr;
  logic [AW-1:0]  ang, diff;
  logic           inside_q, inside_d;
  assign zr       = z_q[CS] + ANG_ROUND;
  assign ang      = zr[Z_W-1 -: AW];
  assign diff     = sweep_neg_q ? start_q - ang : ang - start_q;
  assign inside_d = rad_q[CS+1] && (sweep_full_q || ((AW+2)'(diff) <= sweep_mag_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      sqx_q    <= sqx_d;
      sqy_q    <= sqy_d;
      far_q    <= far_d;
      d2_q     <= d2_d;
      far2_q   <= far_q;
      rad_q    <= rad_d;
      inside_q <= inside_d;
      for (int k = 0; k <= CS; k++) begin
        x_q[k] <= x_d[k];
        y_q[k] <= y_d[k];
        z_q[k] <= z_d[k];
      end
    end
  end

  // output skid entry
  always_comb begin
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (out_ready_i) begin
        skid_v_d = 1'b0;
      end
    end else if (v_q[P-1] && !out_ready_i) begin
      skid_v_d = 1'b1;
      skid_d   = inside_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    skid_q <= skid_d;
  end

  assign out_valid_o  = skid_v_q || v_q[P-1];
  assign inside_res_o = skid_v_q ? skid_q : inside_q;

`ifndef NO_ASSERTIONS
  a_item_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(in_valid_i && in_ready_o) && !(out_valid_o && out_ready_i)) |=>
      ($countones(v_q) + 32'(skid_v_q)) == $past($countones(v_q) + 32'(skid_v_q)))
    else $error("item count changed without a handshake");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |=> $stable(v_q))
    else $error("pipeline advanced while skid entry held");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(v_q[P-1] && !out_ready_i))
    else $error("skid entry filled without a stalled result");
`endif

endmodule

### tb/sector_check_pkg.sv
// Scoreboard for the annular sector hit test: radial test on exact squares and
// a bit-accurate CORDIC angle, checked in order against the block's results.
// Depends on ash_pkg.
package sector_check_pkg;

  import ash_pkg::*;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [ANGLE_WIDTH-1:0] bam_t;

  localparam int CORDIC_SCALE = 29;
  localparam int MAX_REPORTS = 10;
  localparam longint FULL_TURN = 64'sd1 <<< ANGLE_WIDTH;
  localparam longint FAR_LIMIT = 64'sd1 <<< (COORD_WIDTH - 1);
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  class sector_hit_checker;

    typedef struct {
      coord_t px;
      coord_t py;
      bit     hit;
    } hit_t;

    coord_t                  cx;
    coord_t                  cy;
    logic [COORD_WIDTH-2:0]  r_outer;
    logic [COORD_WIDTH-2:0]  r_inner;
    bam_t                    start_bam;
    logic signed [ANGLE_WIDTH+1:0] sweep_bam;
    hit_t                    expected_hits[$];
    int                      mismatches;

    function new();
      cx = '0;
      cy = '0;
      r_outer = '0;
      r_inner = '0;
      start_bam = '0;
      sweep_bam = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CENTER_X: cx = data[COORD_WIDTH-1:0];
        REG_CENTER_Y: cy = data[COORD_WIDTH-1:0];
        REG_OUTER_RADIUS: r_outer = data[COORD_WIDTH-2:0];
        REG_INNER_RADIUS: r_inner = data[COORD_WIDTH-2:0];
        REG_START_ANGLE: start_bam = data[ANGLE_WIDTH-1:0];
        REG_SWEEP_ANGLE: sweep_bam = data[ANGLE_WIDTH+1:0];
        default: ;
      endcase
    endfunction

    function bam_t cordic_bam(longint dx, longint dy);
      longint x;
      longint y;
      longint xs;
      longint ys;
      logic [31:0] z;
      logic [63:0] zr;
      x = dx * (64'sd1 <<< CORDIC_SCALE);
      y = dy * (64'sd1 <<< CORDIC_SCALE);
      z = '0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = HALF_TURN;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_TURNS[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_TURNS[i];
        end
      end
      zr = {32'd0, z} + (64'd1 << (31 - ANGLE_WIDTH));
      return bam_t'(zr >> (32 - ANGLE_WIDTH));
    endfunction

    function bit in_sweep(bam_t ang);
      longint sw;
      longint span;
      bam_t   diff;
      sw = longint'(sweep_bam);
      if (sw >= 0) begin
        if (sw >= FULL_TURN) return 1'b1;
        diff = ang - start_bam;
        span = sw;
      end else begin
        if (-sw >= FULL_TURN) return 1'b1;
        diff = start_bam - ang;
        span = -sw;
      end
      return longint'(diff) <= span;
    endfunction

    function bit predict_inside(coord_t px, coord_t py);
      longint dx;
      longint dy;
      longint ax;
      longint ay;
      longint unsigned d2;
      longint unsigned o2;
      longint unsigned i2;
      longint unsigned ro;
      longint unsigned ri;
      dx = longint'(px) - longint'(cx);
      dy = longint'(py) - longint'(cy);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (ax >= FAR_LIMIT || ay >= FAR_LIMIT) return 1'b0;
      d2 = ax * ax + ay * ay;
      ro = r_outer;
      ri = r_inner;
      o2 = ro * ro;
      i2 = ri * ri;
      if (d2 < o2 && d2 > i2) return in_sweep(cordic_bam(dx, dy));
      return 1'b0;
    endfunction

    function void note_point(coord_t px, coord_t py);
      hit_t h;
      h.px = px;
      h.py = py;
      h.hit = predict_inside(px, py);
      expected_hits.insert(expected_hits.size(), h);
    endfunction

    function void check_result(logic inside_res);
      hit_t h;
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result %0b with no point pending", inside_res);
        return;
      end
      h = expected_hits.pop_front();
      if (inside_res !== h.hit) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("point (%0d, %0d): expected inside_res %0b, got %0b",
                   h.px, h.py, h.hit, inside_res);
      end
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction

  endclass

endpackage

### tb/annular_sector_hit_test_tb.sv
// Top-level testbench for annular_sector_hit_test: directed sector edge cases, then
// random sectors with points swept around each one, under bursty input and output stalls.
// Depends on ash_pkg, sector_check_pkg and the block's RTL.
module annular_sector_hit_test_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ash_pkg::*;
  import sector_check_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES = 20;
  localparam int PHASE_ITEMS = 80;
  localparam longint UNIT = 64'sd1 <<< 16;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int DIR_X [8] = '{1, 1, 0, -1, -1, -1, 0, 1};
  localparam int DIR_Y [8] = '{0, 1, 1, 1, 0, -1, -1, -1};

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_RARELY,
    READY_PERIODIC
  } ready_mode_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  coord_t                point_x = '0;
  coord_t                point_y = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  inside_res;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_CENTER_X;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sector_hit_checker sb = new();

  longint      cur_cx = 0;
  longint      cur_cy = 0;
  longint      cur_ro = 0;
  longint      cur_ri = 0;
  longint      cur_st = 0;
  longint      cur_sw = 0;
  int          idle_cycles = 0;
  int          mode_left = 0;
  int          stall_phase = 0;
  ready_mode_e ready_mode = READY_ALWAYS;

  annular_sector_hit_test dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .point_x_i   (point_x),
    .point_y_i   (point_y),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .inside_res_o(inside_res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 256);
    end else begin
      mode_left--;
    end
    stall_phase++;
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
      READY_RARELY: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((stall_phase % 9) < 4);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_point(point_x, point_y);
      if (out_valid && out_ready) sb.check_result(inside_res);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[annular_sector_hit_test] ERROR");
        $finish;
      end
    end
  end

  task automatic send_point(longint x, longint y);
    in_valid <= 1'b1;
    point_x <= coord_t'(x);
    point_y <= coord_t'(y);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  // Reprogram every register once the pipeline is empty; junk above the radius and angle widths.
  task automatic set_sector(longint cx, longint cy, longint ro, longint ri,
                            longint st, longint sw);
    logic [CFG_DATA_W-1:0] junk;
    in_valid <= 1'b0;
    wait_drained();
    junk = $urandom;
    if (junk[0]) write_cfg(junk[1] ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
    write_cfg(REG_CENTER_X, CFG_DATA_W'(cx));
    write_cfg(REG_CENTER_Y, CFG_DATA_W'(cy));
    write_cfg(REG_OUTER_RADIUS, {junk[2], 31'(ro)});
    write_cfg(REG_INNER_RADIUS, {junk[3], 31'(ri)});
    write_cfg(REG_START_ANGLE, {junk[31:16], 16'(st)});
    write_cfg(REG_SWEEP_ANGLE, {junk[31:18], 18'(sw)});
    cfg_valid <= 1'b0;
    cur_cx = cx;
    cur_cy = cy;
    cur_ro = ro;
    cur_ri = ri;
    cur_st = st;
    cur_sw = sw;
  endtask

  initial begin
    longint cx;
    longint cy;
    longint ro;
    longint ri;
    longint st;
    longint sw;
    longint dx;
    longint dy;
    longint k;
    longint lo_r;
    longint s;
    int     pick;
    int     dir;
    int     burst_left;
    bit     no_gaps;
    real    u;
    real    bam;
    real    rad;
    real    theta;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // registers at reset: empty sector
    send_point(0, 0);
    send_point(COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MAX);

    // quarter sector, edges on both axes
    set_sector(0, 0, 100 * UNIT, 10 * UNIT, 0, 16384);
    send_point(50 * UNIT, 0);
    send_point(0, 50 * UNIT);
    send_point(35 * UNIT, 35 * UNIT);
    send_point(-50 * UNIT, 0);
    send_point(0, 0);
    send_point(10 * UNIT, 0);
    send_point(100 * UNIT, 0);

    set_sector(0, 0, 100 * UNIT, 10 * UNIT, 0, -16384);
    send_point(0, -50 * UNIT);
    send_point(0, 50 * UNIT);

    set_sector(0, 0, 100 * UNIT, 10 * UNIT, 16384, 0);
    send_point(1, 50 * UNIT);
    send_point(50 * UNIT, 50 * UNIT);

    // sweep across zero
    set_sector(0, 0, 100 * UNIT, 10 * UNIT, 60000, 11000);
    send_point(50 * UNIT, 0);
    send_point(50 * UNIT, -5 * UNIT);
    send_point(0, 50 * UNIT);

    set_sector(3 * UNIT, -7 * UNIT, 100 * UNIT, 10 * UNIT, 12345, 65536);
    send_point(-50 * UNIT, -1);
    set_sector(0, 0, 100 * UNIT, 10 * UNIT, 0, -131072);
    send_point(0, -50 * UNIT);

    // inner equal to outer
    set_sector(0, 0, 100 * UNIT, 100 * UNIT, 0, 65536);
    send_point(50 * UNIT, 0);

    // far points against the widest radius
    set_sector(COORD_MIN, 0, COORD_MAX, 0, 0, 65536);
    send_point(COORD_MAX, 0);
    send_point(0, 0);
    send_point(-1, 0);
    send_point(COORD_MIN + 5 * UNIT, 0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick = $urandom_range(0, 99);
      cx = (pick < 75) ? (longint'($signed($urandom)) >>> 7) : longint'($signed($urandom));
      pick = $urandom_range(0, 99);
      cy = (pick < 75) ? (longint'($signed($urandom)) >>> 7) : longint'($signed($urandom));

      k = $urandom_range(4, 31);
      ro = (longint'($urandom) & ((64'sd1 <<< k) - 1)) | (64'sd1 <<< (k - 1));
      if ($urandom_range(0, 19) == 0) ro = COORD_MAX;

      pick = $urandom_range(0, 99);
      if (pick < 70) ri = ro * $urandom_range(0, 95) / 100;
      else if (pick < 82) ri = 0;
      else if (pick < 92) ri = ro;
      else ri = ro + $urandom_range(0, 1000);
      if (ri > COORD_MAX) ri = COORD_MAX;

      st = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) * 8192 : $urandom_range(0, 65535);

      pick = $urandom_range(0, 99);
      if (pick < 55) sw = $urandom_range(0, 40000);
      else if (pick < 65) sw = $urandom_range(0, 8) * 8192;
      else if (pick < 75) sw = $urandom_range(0, 3);
      else if (pick < 88) sw = $urandom_range(65536, 131071);
      else sw = longint'($urandom_range(0, 262143)) - 131072;
      if (pick < 88 && $urandom_range(0, 1) == 1) sw = -sw;

      set_sector(cx, cy, ro, ri, st, sw);

      no_gaps = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 32);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        lo_r = (cur_ri < cur_ro) ? cur_ri : cur_ro;
        pick = $urandom_range(0, 99);
        dx = 0;
        dy = 0;
        if (pick < 60) begin
          u = $urandom / 4294967296.0;
          if (cur_sw >= 65536 || cur_sw <= -65536)
            bam = u * 65536.0;
          else
            bam = real'(cur_st) + real'(cur_sw) * (1.16 * u - 0.08)
                  + real'($urandom_range(0, 40)) - 20.0;
          rad = 0.9 * real'(lo_r)
                + (1.1 * real'(cur_ro) + 8.0 - 0.9 * real'(lo_r)) * ($urandom / 4294967296.0);
          theta = bam * 6.283185307179586 / 65536.0;
          dx = longint'(rad * $cos(theta));
          dy = longint'(rad * $sin(theta));
        end else if (pick < 75) begin
          s = cur_ro + cur_ro / 4 + 16;
          dx = longint'((2.0 * ($urandom / 4294967296.0) - 1.0) * real'(s));
          dy = longint'((2.0 * ($urandom / 4294967296.0) - 1.0) * real'(s));
        end else if (pick < 88) begin
          k = lo_r + longint'(real'(cur_ro - lo_r + 2) * ($urandom / 4294967296.0)) - 1;
          dir = $urandom_range(0, 7);
          if (dir % 2 == 1) k = k * 7 / 10;
          dx = DIR_X[dir] * k;
          dy = DIR_Y[dir] * k;
        end
        if (pick < 88) send_point(cur_cx + dx, cur_cy + dy);
        else send_point($urandom, $urandom);

        burst_left--;
        if (burst_left == 0) begin
          if (!no_gaps) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
          end
          burst_left = $urandom_range(1, 32);
        end
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("[annular_sector_hit_test] OK");
    else
      $display("[annular_sector_hit_test] ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/ash_pkg.sv
rtl/annular_sector_hit_test.sv
tb/sector_check_pkg.sv
tb/annular_sector_hit_test_tb.sv
